/* sv/lppd_pkg.sv */
`timescale 1ns / 1ps

package lppd_pkg;

	// Packet header layout: two tag bytes, property, 16-bit page id, 32-bit length.
	localparam int HEADER_BYTES = 9;
	localparam int HDR_STORE_DEPTH = HEADER_BYTES - 1;
	localparam int HDR_IDX_W = $clog2(HDR_STORE_DEPTH);
	localparam int HDR_CNT_W = $clog2(HEADER_BYTES) + 1;
	localparam logic [HDR_CNT_W-1:0] HDR_LAST = HDR_CNT_W'(HEADER_BYTES - 1);

	localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd16777216;

	// Output queue
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW = FIFO_AW + 1;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_DISCARD = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		K_HEADER = 2'd0,
		K_DATA   = 2'd1,
		K_ABORT  = 2'd2
	} kind_t;

	typedef enum logic {
		CAUSE_TOO_LONG  = 1'b0,
		CAUSE_TRUNCATED = 1'b1
	} cause_t;

	typedef struct packed {
		kind_t        kind;
		logic [7:0]   tag_first;
		logic [7:0]   tag_second;
		logic [7:0]   property_res;
		logic [15:0]  page_id;
		logic [31:0]  payload_length;
		logic [7:0]   payload_data;
		logic         packet_end;
		cause_t       abort_cause;
		logic         last_of_item;
	} result_t;

endpackage

/* sv/length_prefixed_packet_deframer.sv */
`timescale 1ns / 1ps

// Channel   Signals                                   Direction  Carries
// -------   ----------------------------------------  ---------  --------------------------
// in        in_valid/in_ready, data_byte/chunk_end/fin   sink    one link byte per item
// out       out_valid/out_ready, kind ... last_of_item   source  header, data byte or abort
// cfg       cfg_valid/cfg_ready, cfg_data                sink    max_payload register
//
// Path: an item is registered at accept (_s1), decoded from that register and
//   pushed into a 4-entry result queue when decode moves; its first result is
//   valid at the queue head from that push on and can be taken with out_ready.
// Rate: one item per cycle while each item makes at most one result and decode
//   is not stalled; a two-result item needs two pops, one result per cycle.
// Stalls: the decode stage moves only while the queue has room for two results.
// Reset: arst_n clears phase, counters, queue and sets max_payload to 16 MiB.

module length_prefixed_packet_deframer (
	input  logic        clk,
	input  logic        arst_n,
	// input items
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        chunk_end,
	input  logic        fin,
	// result items
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [7:0]  tag_first,
	output logic [7:0]  tag_second,
	output logic [7:0]  property_res,
	output logic [15:0] page_id,
	output logic [31:0] payload_length,
	output logic [7:0]  payload_data,
	output logic        packet_end,
	output logic        abort_cause,
	output logic        last_of_item,
	// configuration
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);
	import lppd_pkg::*;

	// ---------------- input register ----------------
	logic       valid_s1;
	logic [7:0] data_s1;
	logic       cend_s1;
	logic       fin_s1;

	// ---------------- deframer state ----------------
	phase_t                 phase_q, phase_n;
	logic [HDR_CNT_W-1:0]   header_count_q, header_count_n;
	logic [31:0]            bytes_remaining_q, bytes_remaining_n;
	logic [7:0]             header_store_q [HDR_STORE_DEPTH];
	logic                   hdr_wr;
	logic [31:0]            max_payload_q;

	// ---------------- result queue ----------------
	result_t                fifo_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]     wr_ptr_q, rd_ptr_q, wr_ptr_nx;
	logic [FIFO_CW-1:0]     count_q;

	// ---------------- decode signals ----------------
	logic        advance;
	logic        fin_end;
	logic [31:0] len;
	logic [31:0] rem_dec;
	logic        rem_last;
	logic        too_long;
	logic        hdr_full;
	result_t     res0, res1;
	logic [1:0]  n_res;
	logic        pop;

	// Decode moves when the queue can take two more results.
	assign advance  = valid_s1 && (count_q <= FIFO_CW'(FIFO_DEPTH - 2));
	assign in_ready = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= data_byte;
			cend_s1 <= chunk_end;
			fin_s1  <= fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= MAX_PAYLOAD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_payload_q <= cfg_data;
		end
	end

	// fin only matters on the last byte of a chunk
	assign fin_end  = cend_s1 && fin_s1;
	assign len      = {header_store_q[5], header_store_q[6], header_store_q[7], data_s1};
	assign rem_dec  = bytes_remaining_q - 32'd1;
	assign rem_last = (rem_dec == 32'd0);
	assign too_long = (len > max_payload_q);
	assign hdr_full = !(header_count_q < HDR_LAST);

	// ---------------- next state ----------------
	always_comb begin
		phase_n           = phase_q;
		header_count_n    = header_count_q;
		bytes_remaining_n = bytes_remaining_q;
		hdr_wr            = 1'b0;
		case (phase_q)
			PH_DISCARD: begin
				if (cend_s1) begin
					phase_n = PH_HEADER;
				end
			end
			PH_PAYLOAD: begin
				bytes_remaining_n = rem_dec;
				if (rem_last) begin
					phase_n = PH_HEADER;
				end else if (fin_end) begin
					phase_n           = PH_HEADER;
					bytes_remaining_n = 32'd0;
				end
			end
			default: begin
				// unused phase code collects a header too
				phase_n = PH_HEADER;
				if (!hdr_full) begin
					hdr_wr         = 1'b1;
					header_count_n = fin_end ? '0 : header_count_q + 1'b1;
				end else begin
					header_count_n = '0;
					if (too_long) begin
						phase_n = cend_s1 ? PH_HEADER : PH_DISCARD;
					end else if (len != 32'd0 && !fin_end) begin
						bytes_remaining_n = len;
						phase_n           = PH_PAYLOAD;
					end
				end
			end
		endcase
	end

	// ---------------- results ----------------
	always_comb begin
		res0  = '0;
		res1  = '0;
		n_res = 2'd0;
		res1.kind        = K_ABORT;
		res1.abort_cause = CAUSE_TRUNCATED;
		res1.last_of_item = 1'b1;
		case (phase_q)
			PH_DISCARD: begin
				n_res = 2'd0;
			end
			PH_PAYLOAD: begin
				res0.kind         = K_DATA;
				res0.payload_data = data_s1;
				res0.packet_end   = rem_last;
				if (!rem_last && fin_end) begin
					n_res = 2'd2;
				end else begin
					n_res             = 2'd1;
					res0.last_of_item = 1'b1;
				end
			end
			default: begin
				if (!hdr_full) begin
					// final chunk ended inside the header
					res0.kind         = K_ABORT;
					res0.abort_cause  = CAUSE_TRUNCATED;
					res0.last_of_item = 1'b1;
					n_res             = fin_end ? 2'd1 : 2'd0;
				end else if (too_long) begin
					res0.kind         = K_ABORT;
					res0.abort_cause  = CAUSE_TOO_LONG;
					res0.last_of_item = 1'b1;
					n_res             = 2'd1;
				end else begin
					res0.kind           = K_HEADER;
					res0.tag_first      = header_store_q[0];
					res0.tag_second     = header_store_q[1];
					res0.property_res   = header_store_q[2];
					res0.page_id        = {header_store_q[3], header_store_q[4]};
					res0.payload_length = len;
					res0.packet_end     = (len == 32'd0);
					if (len != 32'd0 && fin_end) begin
						n_res = 2'd2;
					end else begin
						n_res             = 2'd1;
						res0.last_of_item = 1'b1;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q           <= PH_HEADER;
			header_count_q    <= '0;
			bytes_remaining_q <= '0;
		end else if (advance) begin
			phase_q           <= phase_n;
			header_count_q    <= header_count_n;
			bytes_remaining_q <= bytes_remaining_n;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && hdr_wr) begin
			header_store_q[header_count_q[HDR_IDX_W-1:0]] <= data_s1;
		end
	end

	// ---------------- result queue ----------------
	assign pop       = out_valid && out_ready;
	assign wr_ptr_nx = wr_ptr_q + 1'b1;

	always_ff @(posedge clk) begin
		if (advance && n_res != 2'd0) begin
			fifo_q[wr_ptr_q] <= res0;
		end
		if (advance && n_res == 2'd2) begin
			fifo_q[wr_ptr_nx] <= res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (advance) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(n_res);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (advance ? FIFO_CW'(n_res) : '0) - FIFO_CW'(pop);
		end
	end

	assign out_valid      = (count_q != '0);
	assign kind           = fifo_q[rd_ptr_q].kind;
	assign tag_first      = fifo_q[rd_ptr_q].tag_first;
	assign tag_second     = fifo_q[rd_ptr_q].tag_second;
	assign property_res   = fifo_q[rd_ptr_q].property_res;
	assign page_id        = fifo_q[rd_ptr_q].page_id;
	assign payload_length = fifo_q[rd_ptr_q].payload_length;
	assign payload_data   = fifo_q[rd_ptr_q].payload_data;
	assign packet_end     = fifo_q[rd_ptr_q].packet_end;
	assign abort_cause    = fifo_q[rd_ptr_q].abort_cause;
	assign last_of_item   = fifo_q[rd_ptr_q].last_of_item;

`ifndef SYNTHESIS
	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FIFO_CW'(FIFO_DEPTH))
		else $error("result queue overfilled");

	a_payload_rem: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> bytes_remaining_q != 32'd0)
		else $error("payload phase with no bytes remaining");

	a_hdr_count: assert property (@(posedge clk) disable iff (!arst_n)
		header_count_q <= HDR_LAST)
		else $error("header count past header length");

	a_discard_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DISCARD |-> header_count_q == '0)
		else $error("discard entered with partial header");
`endif

endmodule

/* bench/deframer_checker.sv */
`timescale 1ns / 1ps

// Watches the three channels, keeps its own model of the deframer and
// compares every output item with the oldest predicted one.
module deframer_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        chunk_end,
	input  logic        fin,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [1:0]  kind,
	input  logic [7:0]  tag_first,
	input  logic [7:0]  tag_second,
	input  logic [7:0]  property_res,
	input  logic [15:0] page_id,
	input  logic [31:0] payload_length,
	input  logic [7:0]  payload_data,
	input  logic        packet_end,
	input  logic        abort_cause,
	input  logic        last_of_item,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [31:0] cfg_data,
	output int          fail_count,
	output int          pending
);
	import lppd_pkg::*;

	result_t     expected_results[$];
	logic [7:0]  hdr_bytes [0:HDR_STORE_DEPTH-1];
	logic [3:0]  hdr_cnt;
	logic [31:0] bytes_left;
	phase_t      framing;
	logic [31:0] max_len;

	function automatic result_t blank_result(kind_t k);
		result_t r;
		r = '0;
		r.kind = k;
		return r;
	endfunction

	function automatic string show(result_t r);
		return $sformatf({"kind=%0d tag=%02h/%02h prop=%02h page=%04h len=%08h",
			" data=%02h end=%b cause=%b last=%b"},
			r.kind, r.tag_first, r.tag_second, r.property_res, r.page_id,
			r.payload_length, r.payload_data, r.packet_end, r.abort_cause,
			r.last_of_item);
	endfunction

	// One link byte through the framing state; queues the items it produces.
	task automatic deframe_byte(input logic [7:0] b, input logic ce, input logic fn);
		result_t     res [0:1];
		int          n;
		logic        fin_end;
		logic [31:0] len;
		n = 0;
		fin_end = ce & fn;
		if (framing == PH_DISCARD) begin
			if (ce)
				framing = PH_HEADER;
		end else if (framing == PH_PAYLOAD) begin
			bytes_left = bytes_left - 32'd1;
			res[n] = blank_result(K_DATA);
			res[n].payload_data = b;
			res[n].packet_end = (bytes_left == 32'd0);
			n++;
			if (bytes_left == 32'd0) begin
				framing = PH_HEADER;
			end else if (fin_end) begin
				res[n] = blank_result(K_ABORT);
				res[n].abort_cause = CAUSE_TRUNCATED;
				n++;
				framing = PH_HEADER;
				bytes_left = 32'd0;
			end
		end else begin
			framing = PH_HEADER;
			if (hdr_cnt < HDR_STORE_DEPTH) begin
				hdr_bytes[hdr_cnt[2:0]] = b;
				hdr_cnt++;
				if (fin_end) begin
					res[n] = blank_result(K_ABORT);
					res[n].abort_cause = CAUSE_TRUNCATED;
					n++;
					hdr_cnt = '0;
				end
			end else begin
				len = {hdr_bytes[5], hdr_bytes[6], hdr_bytes[7], b};
				hdr_cnt = '0;
				if (len > max_len) begin
					res[n] = blank_result(K_ABORT);
					res[n].abort_cause = CAUSE_TOO_LONG;
					n++;
					framing = ce ? PH_HEADER : PH_DISCARD;
				end else begin
					res[n] = blank_result(K_HEADER);
					res[n].tag_first = hdr_bytes[0];
					res[n].tag_second = hdr_bytes[1];
					res[n].property_res = hdr_bytes[2];
					res[n].page_id = {hdr_bytes[3], hdr_bytes[4]};
					res[n].payload_length = len;
					res[n].packet_end = (len == 32'd0);
					n++;
					if (len != 32'd0) begin
						if (fin_end) begin
							res[n] = blank_result(K_ABORT);
							res[n].abort_cause = CAUSE_TRUNCATED;
							n++;
						end else begin
							bytes_left = len;
							framing = PH_PAYLOAD;
						end
					end
				end
			end
		end
		if (n > 0)
			res[n-1].last_of_item = 1'b1;
		for (int i = 0; i < n; i++)
			expected_results.push_back(res[i]);
	endtask

	task automatic check_result();
		result_t got;
		result_t want;
		logic    bad;
		got.kind = kind_t'(kind);
		got.tag_first = tag_first;
		got.tag_second = tag_second;
		got.property_res = property_res;
		got.page_id = page_id;
		got.payload_length = payload_length;
		got.payload_data = payload_data;
		got.packet_end = packet_end;
		got.abort_cause = cause_t'(abort_cause);
		got.last_of_item = last_of_item;
		if (expected_results.size() == 0) begin
			fail_count++;
			if (fail_count <= 10)
				$display("%0t: unexpected item %s", $realtime, show(got));
			return;
		end
		want = expected_results.pop_front();
		bad = (got.kind !== want.kind) || (got.tag_first !== want.tag_first) ||
			(got.tag_second !== want.tag_second) ||
			(got.property_res !== want.property_res) ||
			(got.page_id !== want.page_id) ||
			(got.payload_length !== want.payload_length) ||
			(got.payload_data !== want.payload_data) ||
			(got.packet_end !== want.packet_end) ||
			(got.abort_cause !== want.abort_cause) ||
			(got.last_of_item !== want.last_of_item);
		if (bad) begin
			fail_count++;
			if (fail_count <= 10) begin
				$display("%0t: mismatch expected %s", $realtime, show(want));
				$display("%0t:          actual   %s", $realtime, show(got));
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_results.delete();
			for (int i = 0; i < HDR_STORE_DEPTH; i++)
				hdr_bytes[i] = '0;
			hdr_cnt = '0;
			bytes_left = '0;
			framing = PH_HEADER;
			max_len = MAX_PAYLOAD_RESET;
			fail_count = 0;
			pending = 0;
		end else begin
			if (in_valid && in_ready)
				deframe_byte(data_byte, chunk_end, fin);
			if (out_valid && out_ready)
				check_result();
			if (cfg_valid && cfg_ready)
				max_len = cfg_data;
			pending = expected_results.size();
		end
	end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps

// Deframer bench: drives link bytes, a sink with random backpressure and the
// max_payload register; the checker beside the block does all prediction.
module tb_top;
	import lppd_pkg::*;

	localparam int LIMIT       = 200000;	// cycles, many times the slowest run
	localparam int HOLD_CYCLES = 250;	// long sink stall, fills the block
	localparam int SETTLE      = 8;	// covers the path from _s1 through the queue

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  data_byte;
	logic        chunk_end;
	logic        fin;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  kind;
	logic [7:0]  tag_first;
	logic [7:0]  tag_second;
	logic [7:0]  property_res;
	logic [15:0] page_id;
	logic [31:0] payload_length;
	logic [7:0]  payload_data;
	logic        packet_end;
	logic        abort_cause;
	logic        last_of_item;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [31:0] cfg_data;

	int          fail_count;
	int          pending_results;
	int          cycle_count;
	int          items_sent;
	int          send_idle;	// percent of cycles the sender holds back
	int          recv_idle;	// percent of cycles the sink is not ready
	int          hold_req;	// bumped to ask the sink for one long stall
	logic [31:0] max_len_cfg;	// current limit, only to shape stimulus

	length_prefixed_packet_deframer dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.data_byte      (data_byte),
		.chunk_end      (chunk_end),
		.fin            (fin),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.kind           (kind),
		.tag_first      (tag_first),
		.tag_second     (tag_second),
		.property_res   (property_res),
		.page_id        (page_id),
		.payload_length (payload_length),
		.payload_data   (payload_data),
		.packet_end     (packet_end),
		.abort_cause    (abort_cause),
		.last_of_item   (last_of_item),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data)
	);

	deframer_checker deframe_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.data_byte      (data_byte),
		.chunk_end      (chunk_end),
		.fin            (fin),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.kind           (kind),
		.tag_first      (tag_first),
		.tag_second     (tag_second),
		.property_res   (property_res),
		.page_id        (page_id),
		.payload_length (payload_length),
		.payload_data   (payload_data),
		.packet_end     (packet_end),
		.abort_cause    (abort_cause),
		.last_of_item   (last_of_item),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.fail_count     (fail_count),
		.pending        (pending_results)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Watchdog: a hung handshake or a lost item ends here.
	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Test completed with failures");
		$finish;
	end

	// Sink. Random ready per cycle; a bump of hold_req buys one long stall,
	// counted here so the sender keeps pushing while the block backs up.
	initial begin
		int holds_seen;
		int hold_left;
		holds_seen = 0;
		hold_left = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req != holds_seen) begin
				holds_seen = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_idle);
			end
		end
	end

	// One item on the input channel. Entered and left at a falling edge;
	// valid stays up until the accepting rising edge. The caller follows up
	// in the same step, so valid is never lowered and raised in one step.
	task automatic send_byte(input logic [7:0] b, input logic ce, input logic fn);
		while ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		chunk_end <= ce;
		fin <= fn;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	// Byte inside a packet: chunk ends fall anywhere, but never a final one;
	// fin without chunk_end shows up too and must be ignored.
	task automatic send_mid(input logic [7:0] b);
		logic ce;
		logic fn;
		ce = ($urandom_range(0, 99) < 15);
		fn = ce ? 1'b0 : ($urandom_range(0, 99) < 10);
		send_byte(b, ce, fn);
	endtask

	// Last byte of a packet: a final chunk here is a clean boundary.
	task automatic send_last(input logic [7:0] b);
		send_byte(b, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
	endtask

	// Pause the sender until every predicted item has come out, then let
	// the pipeline settle in case the last bytes produced nothing.
	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (pending_results != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_max_payload(input logic [31:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		max_len_cfg = v;
	endtask

	// A whole packet with random content. Mostly well formed; a few are cut
	// short by a final chunk. Oversized lengths are followed by junk up to a
	// chunk end. Accepted long lengths are always cut so the run stays short.
	// Every exit leaves the block collecting a fresh header.
	task automatic send_packet();
		logic [7:0]  hb [0:8];
		logic [31:0] len;
		int          sel;
		int          cut;
		logic        ce;
		for (int i = 0; i < 9; i++)
			hb[i] = 8'($urandom_range(0, 255));
		sel = $urandom_range(0, 99);
		if (sel < 55)
			len = $urandom_range(0, 10);
		else if (sel < 70)
			len = $urandom_range(11, 40);
		else if (sel < 85)
			len = max_len_cfg + 32'($urandom_range(1, 3));	// just over the limit
		else
			len = $urandom;
		{hb[5], hb[6], hb[7], hb[8]} = len;

		cut = ($urandom_range(0, 99) < 8) ? $urandom_range(0, 14) : -1;
		if (len <= max_len_cfg && len > 32'd40 && cut < 0)
			cut = $urandom_range(8, 14);

		for (int i = 0; i < 8; i++) begin
			if (i == cut) begin
				send_byte(hb[i], 1'b1, 1'b1);	// final chunk inside the header
				return;
			end
			send_mid(hb[i]);
		end
		if (cut == 8) begin
			send_byte(hb[8], 1'b1, 1'b1);
			return;
		end
		if (len > max_len_cfg) begin
			// too long: drop up to the chunk end, or none if it ends here
			ce = 1'($urandom_range(0, 1));
			send_byte(hb[8], ce, 1'($urandom_range(0, 1)));
			if (!ce) begin
				repeat ($urandom_range(0, 4))
					send_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
				send_byte(8'($urandom_range(0, 255)), 1'b1, 1'($urandom_range(0, 1)));
			end
			return;
		end
		if (len == 32'd0) begin
			send_last(hb[8]);
			return;
		end
		send_mid(hb[8]);
		// lengths compared as 32-bit unsigned so huge lengths still loop
		for (int k = 0; 32'(k) < len; k++) begin
			if (9 + k == cut) begin
				send_byte(8'($urandom_range(0, 255)), 1'b1, 1'b1);
				return;
			end
			if (32'(k) == len - 32'd1)
				send_last(8'($urandom_range(0, 255)));
			else
				send_mid(8'($urandom_range(0, 255)));
		end
	endtask

	// Garbage with random flags, then a final chunk end, which always
	// brings framing back to an empty header whatever state it was in.
	task automatic send_noise();
		repeat ($urandom_range(1, 6))
			send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)));
		send_byte(8'($urandom_range(0, 255)), 1'b1, 1'b1);
	endtask

	task automatic run_random(input int target);
		while (items_sent < target) begin
			if ($urandom_range(0, 99) < 12)
				send_noise();
			else
				send_packet();
		end
	endtask

	// Hand-picked sequences at the default limit of 16 MiB.
	task automatic send_directed();
		logic [7:0] hdr [0:8];

		// zero-length header, all-zero fields; ignored fin on a header byte
		hdr = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
		for (int i = 0; i < 8; i++)
			send_byte(hdr[i], 1'b0, (i == 1));
		send_byte(hdr[8], 1'b1, 1'b0);

		// all-ones fields, length 2, final chunk after one payload byte
		hdr = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h02};
		for (int i = 0; i < 9; i++)
			send_byte(hdr[i], 1'b0, 1'b0);
		send_byte(8'hFF, 1'b1, 1'b1);

		// final chunk after the first header byte
		send_byte(8'h5A, 1'b1, 1'b1);

		// maximum length is too long; discard ends at a final chunk end
		hdr = '{8'hAA, 8'h55, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
		for (int i = 0; i < 9; i++)
			send_byte(hdr[i], 1'b0, 1'b0);
		send_byte(8'h33, 1'b1, 1'b1);
	endtask

	// Main sequence: reset, directed items, then four random phases with
	// different limits and idling; the register changes only when idle.
	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = '0;
		chunk_end = 1'b0;
		fin = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		items_sent = 0;
		hold_req = 0;
		send_idle = 20;
		recv_idle = 82;
		max_len_cfg = MAX_PAYLOAD_RESET;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset limit: most full-range random lengths abort
		send_directed();
		run_random(160);
		wait_for_results();

		// limit 0: only empty packets get through
		write_max_payload(32'd0);
		run_random(240);
		wait_for_results();

		// no limit; sender now the slow side
		write_max_payload(32'hFFFF_FFFF);
		send_idle = 82;
		recv_idle = 20;
		run_random(370);
		wait_for_results();

		// small limit, no idling, and one long sink stall to back up the input
		write_max_payload(32'($urandom_range(4, 30)));
		send_idle = 0;
		recv_idle = 0;
		hold_req++;
		run_random(500);
		wait_for_results();

		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
